// ===== hdl/lfr_pkg.sv =====
`default_nettype none
package lfr_pkg;

  // Queue geometry
  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int MAX_RESULTS = 64;

  // Field widths fixed by the channel formats
  localparam int ID_W  = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_MISSING = 2'd1,
    RS_DUP     = 2'd2
  } rstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_B,
    ST_READ,
    ST_UNLINK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic   latch;
    logic   push_self;
    logic   push_a;
    logic   push_b;
    logic   rd;
    logic   rd_head;
    logic   unlink;
    logic   dec_rem;
    logic   emit;
    logic   emit_valid;
    rstat_t emit_status;
    logic   emit_member;
    logic   emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic in_range;
    logic member_in;
    logic count_zero;
    logic pop_zero;
    logic rem_one;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/lfr_req_if.sv =====
`default_nettype none
interface lfr_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [lfr_pkg::ID_W-1:0]    entry_id;
  logic [lfr_pkg::CNT_W-1:0]   pop_count;

  modport source (output valid, output opcode, output entry_id, output pop_count,
                  input ready);
  modport sink (input valid, input opcode, input entry_id, input pop_count,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/lfr_rsp_if.sv =====
`default_nettype none
interface lfr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lfr_pkg::ID_W-1:0]    out_entry;
  logic                        entry_valid;
  logic [1:0]                  status;
  logic                        is_member;
  logic [lfr_pkg::CNT_W-1:0]   queue_size;
  logic                        queue_empty;
  logic                        last;

  modport source (output valid, output out_entry, output entry_valid, output status,
                  output is_member, output queue_size, output queue_empty,
                  output last, input ready);
  modport sink (input valid, input out_entry, input entry_valid, input status,
                input is_member, input queue_size, input queue_empty, input last,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/lfr_ctrl.sv =====
`default_nettype none
module lfr_ctrl import lfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] opcode,
  input  stat_t      stat,
  output logic       req_ready,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   is_pop, is_pop_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      is_pop <= 1'b0;
    end else begin
      state  <= state_next;
      is_pop <= is_pop_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    is_pop_next     = is_pop;
    req_ready       = 1'b0;
    cmd             = '0;
    cmd.emit_status = RS_OK;
    unique case (state)
      ST_IDLE: begin
        req_ready = stat.out_free;
        if (req_valid && stat.out_free) begin
          unique case (opcode_t'(opcode))
            OP_PUSH: begin
              if (!stat.in_range) begin
                cmd.emit = 1'b1; cmd.emit_status = RS_MISSING; cmd.emit_last = 1'b1;
              end else if (stat.member_in) begin
                cmd.emit = 1'b1; cmd.emit_status = RS_DUP; cmd.emit_last = 1'b1;
              end else if (stat.count_zero) begin
                cmd.push_self = 1'b1;
                cmd.emit = 1'b1; cmd.emit_last = 1'b1;
              end else begin
                cmd.push_a = 1'b1;
                cmd.latch  = 1'b1;
                state_next = ST_PUSH_B;
              end
            end
            OP_POP: begin
              if (stat.pop_zero) begin
                cmd.emit = 1'b1; cmd.emit_last = 1'b1;
              end else if (stat.count_zero) begin
                cmd.emit = 1'b1; cmd.emit_status = RS_MISSING; cmd.emit_last = 1'b1;
              end else begin
                cmd.latch   = 1'b1;
                is_pop_next = 1'b1;
                state_next  = ST_READ;
              end
            end
            OP_REMOVE: begin
              if (!stat.in_range || stat.count_zero || !stat.member_in) begin
                cmd.emit = 1'b1; cmd.emit_status = RS_MISSING; cmd.emit_last = 1'b1;
              end else begin
                cmd.latch   = 1'b1;
                is_pop_next = 1'b0;
                state_next  = ST_READ;
              end
            end
            OP_QUERY: begin
              cmd.emit = 1'b1; cmd.emit_member = stat.member_in; cmd.emit_last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_PUSH_B: begin
        // Close the ring once the result slot is free
        if (stat.out_free) begin
          cmd.push_b = 1'b1;
          cmd.emit = 1'b1; cmd.emit_last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd      = 1'b1;
        cmd.rd_head = is_pop;
        state_next  = ST_UNLINK;
      end
      ST_UNLINK: begin
        if (stat.out_free) begin
          cmd.unlink     = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_valid = is_pop;
          cmd.emit_last  = !is_pop || stat.rem_one;
          cmd.dec_rem    = is_pop;
          state_next     = (is_pop && !stat.rem_one) ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/lfr_datapath.sv =====
`default_nettype none
module lfr_datapath import lfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [ID_W-1:0]  entry_id,
  input  logic [CNT_W-1:0] pop_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  out_entry,
  output logic             entry_valid,
  output logic [1:0]       status,
  output logic             is_member,
  output logic [CNT_W-1:0] queue_size,
  output logic             queue_empty,
  output logic             last
);

  logic [IDX_W-1:0] next_mem [ENTRIES];
  logic [IDX_W-1:0] prev_mem [ENTRIES];

  logic [IDX_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [ENTRIES-1:0] member;
  logic [IDX_W-1:0] tgt;
  logic [CNT_W-1:0] rem;
  logic [IDX_W-1:0] rd_next, rd_prev;

  logic [IDX_W-1:0] id_idx, rd_addr;
  logic             in_range;
  logic [CNT_W-1:0] sat, want;
  logic             multi;

  logic             nw_en, pw_en;
  logic [IDX_W-1:0] nw_addr, nw_data, pw_addr, pw_data;

  assign id_idx   = entry_id[IDX_W-1:0];
  assign in_range = int'(entry_id) < ENTRIES;
  assign sat      = (pop_count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : pop_count;
  assign want     = (sat > count) ? count : sat;
  assign multi    = count > CNT_W'(1);
  assign rd_addr  = cmd.rd_head ? head : tgt;

  // Status toward the controller
  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.in_range   = in_range;
    stat.member_in  = in_range && member[id_idx];
    stat.count_zero = (count == '0);
    stat.pop_zero   = (pop_count == '0);
    stat.rem_one    = (rem == CNT_W'(1));
  end

  // Link table write ports
  always_comb begin
    nw_en = 1'b0; nw_addr = id_idx; nw_data = id_idx;
    pw_en = 1'b0; pw_addr = id_idx; pw_data = id_idx;
    priority if (cmd.push_self) begin
      nw_en = 1'b1;
      pw_en = 1'b1;
    end else if (cmd.push_a) begin
      nw_en = 1'b1; nw_addr = tail;
      pw_en = 1'b1; pw_data = tail;
    end else if (cmd.push_b) begin
      nw_en = 1'b1; nw_addr = tgt;     nw_data = head;
      pw_en = 1'b1; pw_addr = head;    pw_data = tgt;
    end else if (cmd.unlink && multi) begin
      nw_en = 1'b1; nw_addr = rd_prev; nw_data = rd_next;
      pw_en = 1'b1; pw_addr = rd_next; pw_data = rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (cmd.rd) begin
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  // Head, tail and count updates
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    priority if (cmd.push_self) begin
      head_next  = id_idx;
      tail_next  = id_idx;
      count_next = CNT_W'(1);
    end else if (cmd.push_b) begin
      tail_next  = tgt;
      count_next = count + CNT_W'(1);
    end else if (cmd.unlink) begin
      if (!multi) begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end else begin
        if (tgt == head) begin
          head_next = rd_next;
        end else if (tgt == tail) begin
          tail_next = rd_prev;
        end
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      member <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (cmd.push_self) member[id_idx] <= 1'b1;
      if (cmd.push_b)    member[tgt]    <= 1'b1;
      if (cmd.unlink)    member[tgt]    <= 1'b0;
    end
  end

  // Working entry and remaining pop count
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tgt <= id_idx;
      rem <= want;
    end else begin
      if (cmd.rd)      tgt <= rd_addr;
      if (cmd.dec_rem) rem <= rem - CNT_W'(1);
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_entry   <= cmd.emit_valid ? ID_W'(tgt) : '0;
      entry_valid <= cmd.emit_valid;
      status      <= cmd.emit_status;
      is_member   <= cmd.emit_member;
      queue_size  <= count_next;
      queue_empty <= (count_next == '0);
      last        <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/linked_fifo_with_removal.sv =====
`default_nettype none
// Channel  Dir  Fields
// req      in   opcode[2], entry_id[6], pop_count[7]
// rsp      out  out_entry[6], entry_valid, status[2], is_member, queue_size[7],
//               queue_empty, last
//
// Query, rejected operations and a push into an empty queue finish in the idle
// state; other pushes also pass through a second push state (two link table writes
// on single-port tables). Remove and each entry of a pop pass through a read state
// and an unlink state: each unlink reads the link tables (registered read) and then
// writes both neighbors. Reset clears head, tail, count and the membership flags;
// link tables are not cleared. A held result blocks acceptance of the next item and
// every step that emits; only the link table read of a pop or remove goes ahead.
module linked_fifo_with_removal import lfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lfr_req_if.sink   req,
  lfr_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .opcode    (req.opcode),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  lfr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .entry_id    (req.entry_id),
    .pop_count   (req.pop_count),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_entry   (rsp.out_entry),
    .entry_valid (rsp.entry_valid),
    .status      (rsp.status),
    .is_member   (rsp.is_member),
    .queue_size  (rsp.queue_size),
    .queue_empty (rsp.queue_empty),
    .last        (rsp.last)
  );

  // A result is only loaded into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("result loaded over a held result");

  // Unlink only runs on a non-empty queue
  a_unlink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |-> !stat.count_zero) else $error("unlink on empty queue");

  // Reported emptiness agrees with the reported size
  a_empty_size: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.queue_empty == (rsp.queue_size == '0)))
    else $error("queue_empty disagrees with queue_size");

  // A popped entry always comes with ok status
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.entry_valid) |-> (rsp.status == RS_OK))
    else $error("popped entry with error status");

endmodule
`default_nettype wire
